// ===== rtl/udiv_pkg.sv =====
// shared types and constants for the 128-bit divider
`timescale 1ns / 1ps

package udiv_pkg;

    localparam int unsigned HALF_W = 64;
    localparam int unsigned DIV_W  = 2 * HALF_W;
    localparam int unsigned CNT_W  = $clog2(DIV_W);

    typedef struct packed {
        logic [HALF_W-1:0] dividend_high;
        logic [HALF_W-1:0] dividend_low;
        logic [HALF_W-1:0] divisor_high;
        logic [HALF_W-1:0] divisor_low;
    } t_in_word;

    typedef struct packed {
        logic [HALF_W-1:0] quotient_high;
        logic [HALF_W-1:0] quotient_low;
        logic [HALF_W-1:0] remainder_high;
        logic [HALF_W-1:0] remainder_low;
        logic              divide_by_zero;
    } t_out_word;

    typedef struct packed {
        logic load;
        logic step;
        logic publish;
    } t_dp_cmd;

    typedef struct packed {
        logic dbz;
    } t_dp_stat;

endpackage

// ===== rtl/udiv_in_if.sv =====
// input channel carrying dividend and divisor words
`timescale 1ns / 1ps

interface udiv_in_if;
    import udiv_pkg::*;

    logic     valid;
    logic     ready;
    t_in_word data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// ===== rtl/udiv_out_if.sv =====
// output channel carrying quotient and remainder words
`timescale 1ns / 1ps

interface udiv_out_if;
    import udiv_pkg::*;

    logic      valid;
    logic      ready;
    t_out_word data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// ===== rtl/udiv_datapath.sv =====
// shift-subtract datapath with operand, remainder and result registers
`timescale 1ns / 1ps

module udiv_datapath (
    input  logic               i_clk,
    input  udiv_pkg::t_dp_cmd  i_cmd,
    input  udiv_pkg::t_in_word i_word,
    output udiv_pkg::t_dp_stat o_stat,
    output udiv_pkg::t_out_word o_word
);
    import udiv_pkg::*;

    logic [DIV_W-1:0] r_rem;
    logic [DIV_W-1:0] r_num;
    logic [DIV_W-1:0] r_den;
    logic             r_dbz;
    t_out_word        r_out;

    logic [DIV_W:0]   s_rem_sh;
    logic [DIV_W+1:0] s_diff;
    logic             s_ge;
    logic [DIV_W-1:0] n_rem;

    // shift in the next dividend bit, trial subtract with carry kept
    assign s_rem_sh = {r_rem, r_num[DIV_W-1]};
    assign s_diff   = {1'b0, s_rem_sh} - {2'b00, r_den};
    assign s_ge     = ~s_diff[DIV_W+1];
    assign n_rem    = s_ge ? s_diff[DIV_W-1:0] : s_rem_sh[DIV_W-1:0];

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_rem <= '0;
            r_num <= {i_word.dividend_high, i_word.dividend_low};
            r_den <= {i_word.divisor_high, i_word.divisor_low};
            r_dbz <= ({i_word.divisor_high, i_word.divisor_low} == '0);
        end else if (i_cmd.step) begin
            r_rem <= n_rem;
            r_num <= {r_num[DIV_W-2:0], s_ge};
        end
        if (i_cmd.publish) begin
            if (r_dbz) begin
                r_out.quotient_high  <= '0;
                r_out.quotient_low   <= '0;
                r_out.remainder_high <= '0;
                r_out.remainder_low  <= '0;
                r_out.divide_by_zero <= 1'b1;
            end else begin
                r_out.quotient_high  <= r_num[DIV_W-1:HALF_W];
                r_out.quotient_low   <= r_num[HALF_W-1:0];
                r_out.remainder_high <= r_rem[DIV_W-1:HALF_W];
                r_out.remainder_low  <= r_rem[HALF_W-1:0];
                r_out.divide_by_zero <= 1'b0;
            end
        end
    end

    assign o_stat.dbz = r_dbz;
    assign o_word     = r_out;

endmodule

// ===== rtl/udiv_ctrl.sv =====
// controller sequencing load, bit steps and result hand-off
`timescale 1ns / 1ps

module udiv_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    input  udiv_pkg::t_dp_stat i_stat,
    output udiv_pkg::t_dp_cmd  o_cmd
);
    import udiv_pkg::*;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_RUN  = 2'd1;
    localparam logic [1:0] ST_FIN  = 2'd2;

    logic [1:0]       r_state;
    logic [1:0]       n_state;
    logic [CNT_W-1:0] r_cnt;
    logic [CNT_W-1:0] n_cnt;
    logic             r_out_valid;
    logic             n_out_valid;
    logic             s_accept;
    logic             s_slot_free;

    assign o_in_ready  = (r_state == ST_IDLE);
    assign s_accept    = i_in_valid && o_in_ready;
    assign s_slot_free = !r_out_valid || i_out_ready;

    always_comb begin
        n_state     = r_state;
        n_cnt       = r_cnt;
        n_out_valid = r_out_valid && !i_out_ready;
        o_cmd       = '0;
        case (r_state)
            ST_IDLE: begin
                if (s_accept) begin
                    o_cmd.load = 1'b1;
                    n_cnt      = '0;
                    n_state    = ST_RUN;
                end
            end
            ST_RUN: begin
                if (i_stat.dbz) begin
                    n_state = ST_FIN;
                end else begin
                    o_cmd.step = 1'b1;
                    n_cnt      = r_cnt + 1'b1;
                    if (r_cnt == CNT_W'(DIV_W - 1)) begin
                        n_state = ST_FIN;
                    end
                end
            end
            ST_FIN: begin
                if (s_slot_free) begin
                    o_cmd.publish = 1'b1;
                    n_out_valid   = 1'b1;
                    n_state       = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;

endmodule

// ===== rtl/unsigned_128_bit_divider.sv =====
// unsigned 128-bit restoring divider, top level
// a taken word is loaded, stepped once per dividend bit, then published; a zero divisor skips the steps
// no new word is taken until the last is published; each step is one 129-bit trial subtract
// a finished word waits in the output register while the next division runs
// reset: synchronous active-low i_rst_n clears controller state and output valid
// operand and result data registers are not reset
`timescale 1ns / 1ps

module unsigned_128_bit_divider (
    input  logic       i_clk,
    input  logic       i_rst_n,
    udiv_in_if.sink    i_div,
    udiv_out_if.source o_res
);
    import udiv_pkg::*;

    t_dp_cmd  s_cmd;
    t_dp_stat s_stat;

    udiv_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_div.valid),
        .o_in_ready  (i_div.ready),
        .o_out_valid (o_res.valid),
        .i_out_ready (o_res.ready),
        .i_stat      (s_stat),
        .o_cmd       (s_cmd)
    );

    udiv_datapath u_dp (
        .i_clk  (i_clk),
        .i_cmd  (s_cmd),
        .i_word (i_div.data),
        .o_stat (s_stat),
        .o_word (o_res.data)
    );

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_div.valid && i_div.ready) |=> !i_div.ready)
        else $error("divider ready right after taking a word");

    a_dbz_zero_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res.valid && o_res.data.divide_by_zero) |->
        (o_res.data.quotient_high == '0 && o_res.data.quotient_low == '0 &&
         o_res.data.remainder_high == '0 && o_res.data.remainder_low == '0))
        else $error("nonzero result with divide by zero");

    a_dbz_no_steps: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_div.valid && i_div.ready &&
         i_div.data.divisor_high == '0 && i_div.data.divisor_low == '0) |=> !s_cmd.step)
        else $error("steps run for a zero divisor");

    a_cmd_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({s_cmd.load, s_cmd.step, s_cmd.publish}))
        else $error("datapath commands overlap");

endmodule
